// ===== rtl/core/wpvs_pkg.sv =====
package wpvs_pkg;

  localparam int unsigned VolW = 10;
  localparam int unsigned TotW = 24;
  localparam int unsigned CremW = 25;
  localparam int unsigned QDepth = 4;
  localparam int unsigned QPtrW = 2;
  localparam int unsigned MaxFileBytesDef = 8388608;

  localparam logic [VolW-1:0] VolReset = 10'd1000;
  localparam logic [25:0] Div = 26'd1000;
  localparam logic [22:0] RecipK = 23'd4294967;
  localparam logic [TotW:0] MinFileBytes = 25'd44;

  localparam logic [31:0] TagRiff = 32'h52494646;
  localparam logic [31:0] TagWave = 32'h57415645;
  localparam logic [31:0] TagFmt = 32'h666D7420;
  localparam logic [31:0] TagData = 32'h64617461;

  localparam logic [15:0] FmtPcm = 16'd1;
  localparam logic RegVolume = 1'b0;
  localparam logic RegTotal = 1'b1;

  typedef enum logic [2:0] {
    PH_HEADER,
    PH_CHUNK_HDR,
    PH_SKIP,
    PH_FMT,
    PH_DATA8,
    PH_DATA16,
    PH_DONE
  } phase_e;

  typedef enum logic [1:0] {
    K_PASS,
    K_S8,
    K_S16
  } kind_e;

  typedef struct packed {
    kind_e       kind;
    logic [15:0] data;
    logic        last;
    logic        scaled;
  } qitem_t;

endpackage

// ===== rtl/core/wav_pcm_volume_scaler_unit.sv =====
// Channel   Handshake                  Payload
// input     in_valid_i / in_stall_o    in_byte_i
// output    out_valid_o / out_stall_i  out_byte_o, run_last_o, file_end_o, was_scaled_o
// config    psel/penable/pwrite/pready paddr, pwdata, prdata
//
// One input item is accepted per cycle while the queue is not full; a 16-bit sample
// gives two result items, low byte then high byte, and the output register sets the
// rate at one result per cycle while out_stall_i is low. An accepted item passes
// through the queue, the multiply and reciprocal stages and the output register.
// Reset clears the parser, the queue and all valid flags; volume resets to 1000.
// The input stalls only when the four-entry queue is full.
module wav_pcm_volume_scaler_unit #(
  parameter int unsigned MaxFileBytes = wpvs_pkg::MaxFileBytesDef
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [7:0]  in_byte_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [7:0]  out_byte_o,
  output logic        run_last_o,
  output logic        file_end_o,
  output logic        was_scaled_o,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  import wpvs_pkg::*;

  logic [VolW-1:0] vol_q;
  logic [TotW-1:0] tot_q;
  logic            cfg_wr;
  logic            q_full;
  logic            push;
  qitem_t          push_item;
  logic            q_valid;
  qitem_t          q_head;
  logic            q_pop;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vol_q <= VolReset;
      tot_q <= '0;
    end else if (cfg_wr) begin
      unique case (paddr[2])
        RegVolume: vol_q <= pwdata[VolW-1:0];
        default:   tot_q <= pwdata[TotW-1:0];
      endcase
    end
  end

  always_comb begin
    unique case (paddr[2])
      RegVolume: prdata = {22'b0, vol_q};
      default:   prdata = {8'b0, tot_q};
    endcase
  end

  wpvs_front #(
    .MaxFileBytes(MaxFileBytes)
  ) u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_byte_i    (in_byte_i),
    .in_stall_o   (in_stall_o),
    .total_bytes_i(tot_q),
    .q_full_i     (q_full),
    .push_o       (push),
    .push_item_o  (push_item)
  );

  wpvs_queue u_queue (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (push),
    .push_item_i(push_item),
    .full_o     (q_full),
    .pop_i      (q_pop),
    .valid_o    (q_valid),
    .head_o     (q_head)
  );

  wpvs_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .q_valid_i   (q_valid),
    .q_item_i    (q_head),
    .q_pop_o     (q_pop),
    .volume_i    (vol_q),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_byte_o  (out_byte_o),
    .run_last_o  (run_last_o),
    .file_end_o  (file_end_o),
    .was_scaled_o(was_scaled_o)
  );

  a_pair_follows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_stall_i && !run_last_o |=> out_valid_o && run_last_o)
    else $error("high byte of a sample did not follow its low byte");

  a_end_is_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && file_end_o |-> run_last_o)
    else $error("file end flagged on a result that is not the last of its item");

  a_scaled_at_end: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && was_scaled_o |-> file_end_o)
    else $error("scaled flag reported away from the file end");

endmodule

// ===== rtl/core/wpvs_front.sv =====
module wpvs_front #(
  parameter int unsigned MaxFileBytes = wpvs_pkg::MaxFileBytesDef
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      in_valid_i,
  input  logic [7:0]                in_byte_i,
  output logic                      in_stall_o,
  input  logic [wpvs_pkg::TotW-1:0] total_bytes_i,
  input  logic                      q_full_i,
  output logic                      push_o,
  output wpvs_pkg::qitem_t          push_item_o
);
  import wpvs_pkg::*;

  localparam logic [TotW:0] MaxB = (TotW + 1)'(MaxFileBytes);

  phase_e            phase_q, phase_d;
  logic [TotW-1:0]   pos_q, pos_d;
  logic [CremW-1:0]  crem_q, crem_d;
  logic [63:0]       shift_q, shift_d;
  logic [4:0]        fmt_off_q, fmt_off_d;
  logic [15:0]       fmt_tag_q, fmt_tag_d;
  logic [15:0]       bits_q, bits_d;
  logic [7:0]        held_q, held_d;
  logic              pend_q, pend_d;
  logic              scaled_q, scaled_d;

  logic              accept;
  logic              last;
  logic              room_ok;
  logic [63:0]       shift_nx;
  logic [31:0]       hdr_id;
  logic [31:0]       hdr_lo;
  logic [31:0]       hdr_len;
  logic [TotW:0]     body;
  logic [TotW:0]     avail;
  logic              hdr_fail;
  logic [CremW-1:0]  padded;
  logic [CremW-1:0]  rem_nx;
  logic              fmt_ok;

  assign accept = in_valid_i && !q_full_i;
  assign in_stall_o = q_full_i;

  assign last = ({1'b0, pos_q} + 25'd1) >= {1'b0, total_bytes_i};
  assign room_ok = ({2'b00, pos_q} + 26'd9) <= {2'b00, total_bytes_i};
  assign shift_nx = {shift_q[55:0], in_byte_i};
  assign hdr_id = shift_nx[63:32];
  assign hdr_lo = shift_nx[31:0];
  assign hdr_len = {hdr_lo[7:0], hdr_lo[15:8], hdr_lo[23:16], hdr_lo[31:24]};
  assign body = {1'b0, pos_q} + 25'd1;
  assign avail = {1'b0, total_bytes_i} - body;
  assign hdr_fail = (body > {1'b0, total_bytes_i}) || ({1'b0, hdr_len} > {8'b0, avail});
  assign padded = hdr_len[CremW-1:0] + {{(CremW-1){1'b0}}, hdr_len[0]};
  assign rem_nx = crem_q - 25'd1;
  assign fmt_ok = (fmt_tag_q == FmtPcm) && ((bits_q == 16'd8) || (bits_q == 16'd16));

  always_comb begin
    phase_d   = phase_q;
    pos_d     = pos_q;
    crem_d    = crem_q;
    shift_d   = shift_q;
    fmt_off_d = fmt_off_q;
    fmt_tag_d = fmt_tag_q;
    bits_d    = bits_q;
    held_d    = held_q;
    pend_d    = pend_q;
    scaled_d  = scaled_q;
    push_o    = 1'b0;
    push_item_o.kind   = K_PASS;
    push_item_o.data   = {8'h00, in_byte_i};
    push_item_o.last   = last;
    push_item_o.scaled = 1'b0;
    if (accept) begin
      unique case (phase_q)
        PH_HEADER: begin
          push_o = 1'b1;
          shift_d = shift_nx;
          if ((pos_q == 24'd3) && (shift_nx[31:0] != TagRiff)) begin
            phase_d = PH_DONE;
          end else if (pos_q == 24'd11) begin
            if ((shift_nx[31:0] != TagWave) || ({1'b0, total_bytes_i} < MinFileBytes) ||
                ({1'b0, total_bytes_i} > MaxB) || !room_ok) begin
              phase_d = PH_DONE;
            end else begin
              phase_d = PH_CHUNK_HDR;
              crem_d  = 25'd8;
              shift_d = '0;
            end
          end
        end
        PH_CHUNK_HDR: begin
          push_o = 1'b1;
          shift_d = shift_nx;
          crem_d = rem_nx;
          if (rem_nx == '0) begin
            priority if (hdr_fail) begin
              phase_d = PH_DONE;
            end else if ((hdr_id == TagFmt) && (hdr_len >= 32'd16)) begin
              phase_d   = PH_FMT;
              fmt_off_d = '0;
              crem_d    = padded;
            end else if (hdr_id == TagData) begin
              if (!fmt_ok) begin
                phase_d = PH_DONE;
              end else begin
                scaled_d = 1'b1;
                crem_d   = hdr_len[CremW-1:0];
                if (hdr_len == 32'd0) begin
                  phase_d = PH_DONE;
                end else if (bits_q == 16'd8) begin
                  phase_d = PH_DATA8;
                end else begin
                  phase_d = PH_DATA16;
                end
              end
            end else begin
              phase_d = PH_SKIP;
              crem_d  = padded;
              if (padded == '0) begin
                if (room_ok) begin
                  phase_d = PH_CHUNK_HDR;
                  crem_d  = 25'd8;
                  shift_d = '0;
                end else begin
                  phase_d = PH_DONE;
                end
              end
            end
          end
        end
        PH_SKIP, PH_FMT: begin
          push_o = 1'b1;
          if (phase_q == PH_FMT) begin
            if (fmt_off_q == 5'd0) fmt_tag_d = {fmt_tag_q[15:8], in_byte_i};
            if (fmt_off_q == 5'd1) fmt_tag_d = {in_byte_i, fmt_tag_q[7:0]};
            if (fmt_off_q == 5'd14) bits_d = {bits_q[15:8], in_byte_i};
            if (fmt_off_q == 5'd15) bits_d = {in_byte_i, bits_q[7:0]};
            if (fmt_off_q != 5'd16) fmt_off_d = fmt_off_q + 5'd1;
          end
          crem_d = rem_nx;
          if (rem_nx == '0) begin
            if (room_ok) begin
              phase_d = PH_CHUNK_HDR;
              crem_d  = 25'd8;
              shift_d = '0;
            end else begin
              phase_d = PH_DONE;
            end
          end
        end
        PH_DATA8: begin
          push_o = 1'b1;
          push_item_o.kind = K_S8;
          crem_d = rem_nx;
          if (rem_nx == '0) phase_d = PH_DONE;
        end
        PH_DATA16: begin
          if (pend_q) begin
            push_o = 1'b1;
            push_item_o.kind = K_S16;
            push_item_o.data = {in_byte_i, held_q};
            pend_d = 1'b0;
            held_d = '0;
          end else if ((crem_q == 25'd1) || last) begin
            push_o = 1'b1;
          end else begin
            held_d = in_byte_i;
            pend_d = 1'b1;
          end
          crem_d = rem_nx;
          if (rem_nx == '0) phase_d = PH_DONE;
        end
        default: begin
          push_o = 1'b1;
        end
      endcase
      push_item_o.scaled = scaled_d;
      pos_d = pos_q + 24'd1;
      if (last) begin
        phase_d   = PH_HEADER;
        pos_d     = '0;
        crem_d    = '0;
        shift_d   = '0;
        fmt_off_d = '0;
        fmt_tag_d = '0;
        bits_d    = '0;
        held_d    = '0;
        pend_d    = 1'b0;
        scaled_d  = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q   <= PH_HEADER;
      pos_q     <= '0;
      crem_q    <= '0;
      shift_q   <= '0;
      fmt_off_q <= '0;
      fmt_tag_q <= '0;
      bits_q    <= '0;
      held_q    <= '0;
      pend_q    <= 1'b0;
      scaled_q  <= 1'b0;
    end else begin
      phase_q   <= phase_d;
      pos_q     <= pos_d;
      crem_q    <= crem_d;
      shift_q   <= shift_d;
      fmt_off_q <= fmt_off_d;
      fmt_tag_q <= fmt_tag_d;
      bits_q    <= bits_d;
      held_q    <= held_d;
      pend_q    <= pend_d;
      scaled_q  <= scaled_d;
    end
  end

endmodule

// ===== rtl/core/wpvs_queue.sv =====
module wpvs_queue (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  wpvs_pkg::qitem_t push_item_i,
  output logic             full_o,
  input  logic             pop_i,
  output logic             valid_o,
  output wpvs_pkg::qitem_t head_o
);
  import wpvs_pkg::*;

  qitem_t           mem [QDepth];
  logic [QPtrW-1:0] wr_q;
  logic [QPtrW-1:0] rd_q;
  logic [QPtrW:0]   cnt_q;
  logic             do_push;
  logic             do_pop;

  assign full_o  = cnt_q == (QPtrW + 1)'(QDepth);
  assign valid_o = cnt_q != '0;
  assign head_o  = mem[rd_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && valid_o;

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem[wr_q] <= push_item_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (do_push) wr_q <= wr_q + 1'b1;
      if (do_pop) rd_q <= rd_q + 1'b1;
      cnt_q <= cnt_q + (QPtrW + 1)'(do_push) - (QPtrW + 1)'(do_pop);
    end
  end

endmodule

// ===== rtl/core/wpvs_back.sv =====
module wpvs_back (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      q_valid_i,
  input  wpvs_pkg::qitem_t          q_item_i,
  output logic                      q_pop_o,
  input  logic [wpvs_pkg::VolW-1:0] volume_i,
  output logic                      out_valid_o,
  input  logic                      out_stall_i,
  output logic [7:0]                out_byte_o,
  output logic                      run_last_o,
  output logic                      file_end_o,
  output logic                      was_scaled_o
);
  import wpvs_pkg::*;

  // Stage 1: signed sample times volume.
  logic               s1_v_q;
  kind_e              s1_kind_q;
  logic [7:0]         s1_byte_q;
  logic               s1_last_q;
  logic               s1_scaled_q;
  logic signed [27:0] s1_prod_q;
  logic signed [16:0] smp;
  logic signed [27:0] prod;

  // Stage 2: magnitude and reciprocal estimate of the quotient.
  logic               s2_v_q;
  kind_e              s2_kind_q;
  logic [7:0]         s2_byte_q;
  logic               s2_last_q;
  logic               s2_scaled_q;
  logic               s2_neg_q;
  logic [25:0]        s2_mag_q;
  logic [15:0]        s2_qe_q;
  logic [27:0]        mag;
  logic [48:0]        recip;

  // Output register with a second slot for the high byte of a sample.
  logic               out_v_q, out_v_d;
  logic [7:0]         out_byte_q, out_byte_d;
  logic               out_rl_q, out_rl_d;
  logic               out_fe_q, out_fe_d;
  logic               out_ws_q, out_ws_d;
  logic               hi_pend_q, hi_pend_d;
  logic [7:0]         hi_byte_q, hi_byte_d;
  logic               hi_fe_q, hi_fe_d;
  logic               hi_ws_q, hi_ws_d;

  logic [25:0]        qk;
  logic [25:0]        remd;
  logic [16:0]        qfix;
  logic signed [17:0] vs;
  logic signed [17:0] r8;
  logic [7:0]         res8;
  logic [15:0]        res16;

  logic               load_ok;
  logic               adv2;
  logic               adv1;

  assign load_ok = !out_v_q || (!out_stall_i && !hi_pend_q);
  assign adv2    = !s2_v_q || load_ok;
  assign adv1    = !s1_v_q || adv2;
  assign q_pop_o = q_valid_i && adv1;

  always_comb begin
    if (q_item_i.kind == K_S16) begin
      smp = $signed({q_item_i.data[15], q_item_i.data});
    end else begin
      smp = $signed({9'b0, q_item_i.data[7:0]}) - 17'sd128;
    end
    prod = smp * $signed({1'b0, volume_i});
  end

  assign mag   = s1_prod_q[27] ? (28'd0 - s1_prod_q) : s1_prod_q;
  assign recip = 49'(mag[25:0]) * 49'(RecipK);

  always_comb begin
    qk    = 26'(s2_qe_q) * Div;
    remd  = s2_mag_q - qk;
    qfix  = {1'b0, s2_qe_q} + {16'b0, remd >= Div};
    vs    = s2_neg_q ? $signed(18'd0 - {1'b0, qfix}) : $signed({1'b0, qfix});
    r8    = vs + 18'sd128;
    if (r8 < 18'sd0) begin
      res8 = 8'd0;
    end else if (r8 > 18'sd255) begin
      res8 = 8'd255;
    end else begin
      res8 = r8[7:0];
    end
    if (vs < -18'sd32768) begin
      res16 = 16'h8000;
    end else if (vs > 18'sd32767) begin
      res16 = 16'h7FFF;
    end else begin
      res16 = vs[15:0];
    end
  end

  always_comb begin
    out_v_d    = out_v_q;
    out_byte_d = out_byte_q;
    out_rl_d   = out_rl_q;
    out_fe_d   = out_fe_q;
    out_ws_d   = out_ws_q;
    hi_pend_d  = hi_pend_q;
    hi_byte_d  = hi_byte_q;
    hi_fe_d    = hi_fe_q;
    hi_ws_d    = hi_ws_q;
    if (out_v_q && !out_stall_i) begin
      if (hi_pend_q) begin
        out_byte_d = hi_byte_q;
        out_rl_d   = 1'b1;
        out_fe_d   = hi_fe_q;
        out_ws_d   = hi_ws_q;
        hi_pend_d  = 1'b0;
      end else begin
        out_v_d = 1'b0;
      end
    end
    if (s2_v_q && load_ok) begin
      out_v_d = 1'b1;
      unique case (s2_kind_q)
        K_S16: begin
          out_byte_d = res16[7:0];
          out_rl_d   = 1'b0;
          out_fe_d   = 1'b0;
          out_ws_d   = 1'b0;
          hi_pend_d  = 1'b1;
          hi_byte_d  = res16[15:8];
          hi_fe_d    = s2_last_q;
          hi_ws_d    = s2_last_q && s2_scaled_q;
        end
        K_S8: begin
          out_byte_d = res8;
          out_rl_d   = 1'b1;
          out_fe_d   = s2_last_q;
          out_ws_d   = s2_last_q && s2_scaled_q;
        end
        default: begin
          out_byte_d = s2_byte_q;
          out_rl_d   = 1'b1;
          out_fe_d   = s2_last_q;
          out_ws_d   = s2_last_q && s2_scaled_q;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_v_q    <= 1'b0;
      s2_v_q    <= 1'b0;
      out_v_q   <= 1'b0;
      hi_pend_q <= 1'b0;
    end else begin
      if (adv1) s1_v_q <= q_valid_i;
      if (adv2) s2_v_q <= s1_v_q;
      out_v_q   <= out_v_d;
      hi_pend_q <= hi_pend_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv1) begin
      s1_kind_q   <= q_item_i.kind;
      s1_byte_q   <= q_item_i.data[7:0];
      s1_last_q   <= q_item_i.last;
      s1_scaled_q <= q_item_i.scaled;
      s1_prod_q   <= prod;
    end
    if (adv2) begin
      s2_kind_q   <= s1_kind_q;
      s2_byte_q   <= s1_byte_q;
      s2_last_q   <= s1_last_q;
      s2_scaled_q <= s1_scaled_q;
      s2_neg_q    <= s1_prod_q[27];
      s2_mag_q    <= mag[25:0];
      s2_qe_q     <= recip[47:32];
    end
    out_byte_q <= out_byte_d;
    out_rl_q   <= out_rl_d;
    out_fe_q   <= out_fe_d;
    out_ws_q   <= out_ws_d;
    hi_byte_q  <= hi_byte_d;
    hi_fe_q    <= hi_fe_d;
    hi_ws_q    <= hi_ws_d;
  end

  assign out_valid_o  = out_v_q;
  assign out_byte_o   = out_byte_q;
  assign run_last_o   = out_rl_q;
  assign file_end_o   = out_fe_q;
  assign was_scaled_o = out_ws_q;

endmodule

// ===== tb/tb_wav_pcm_volume_scaler_unit.sv =====
`timescale 1ns / 1ps

module tb_wav_pcm_volume_scaler_unit;
  import wpvs_pkg::*;

  typedef struct packed {
    logic [7:0] value;
    logic       run_last;
    logic       file_end;
    logic       was_scaled;
  } out_byte_t;

  typedef enum int unsigned {
    F_NONE,
    F_BITS,
    F_FORMAT,
    F_RIFF,
    F_WAVE,
    F_LONG,
    F_TRUNC,
    F_ORDER,
    F_SHORTFMT,
    F_HUGE
  } flaw_e;

  class wav_stream_checker;
    logic [9:0]  vol;
    logic [23:0] total;
    phase_e      phase;
    logic [23:0] pos;
    logic [63:0] crem;
    logic [63:0] hsh;
    logic [15:0] fmt_tag;
    logic [15:0] bits;
    logic [7:0]  held;
    bit          pending;
    bit          scaled;
    out_byte_t   due_q[$];
    int unsigned errs;

    function new();
      vol = VolReset;
      total = '0;
      errs = 0;
      clear_parse();
    endfunction

    function void clear_parse();
      phase = PH_HEADER;
      pos = '0;
      crem = '0;
      hsh = '0;
      fmt_tag = '0;
      bits = '0;
      held = '0;
      pending = 0;
      scaled = 0;
    endfunction

    function void set_reg(input logic idx, input logic [31:0] v);
      if (idx == RegVolume) begin
        vol = v[9:0];
      end else begin
        total = v[23:0];
      end
    endfunction

    function void enter_hdr(input logic [63:0] nxt);
      if (nxt + 64'd8 > {40'd0, total}) begin
        phase = PH_DONE;
      end else begin
        phase = PH_CHUNK_HDR;
        crem = 64'd8;
        hsh = '0;
      end
    endfunction

    function void flag(input string msg);
      errs++;
      if (errs <= 10) begin
        $display("%s", msg);
      end
    endfunction

    // Works out the result items that one accepted input byte causes.
    function void note_byte(input logic [7:0] b);
      logic [7:0]         r[2];
      int                 n;
      bit                 last;
      logic [31:0]        lo;
      logic [31:0]        id;
      logic [31:0]        len;
      logic [63:0]        body;
      logic [63:0]        tot64;
      logic signed [15:0] w;
      int                 s;
      int                 v;
      out_byte_t          item;
      n = 0;
      last = ({8'd0, pos} + 32'd1 >= {8'd0, total});
      tot64 = {40'd0, total};
      case (phase)
        PH_HEADER: begin
          hsh = {hsh[55:0], b};
          r[0] = b;
          n = 1;
          if (pos == 24'd3 && hsh[31:0] != TagRiff) begin
            phase = PH_DONE;
          end else if (pos == 24'd11) begin
            if (hsh[31:0] != TagWave || 32'(total) < 32'd44 || 32'(total) > MaxFileBytesDef) begin
              phase = PH_DONE;
            end else begin
              enter_hdr(64'd12);
            end
          end
        end
        PH_CHUNK_HDR: begin
          hsh = {hsh[55:0], b};
          r[0] = b;
          n = 1;
          crem--;
          if (crem == 0) begin
            lo = hsh[31:0];
            id = hsh[63:32];
            len = {lo[7:0], lo[15:8], lo[23:16], lo[31:24]};
            body = {40'd0, pos} + 64'd1;
            if (body > tot64 || {32'd0, len} > tot64 - body) begin
              phase = PH_DONE;
            end else if (id == TagFmt && len >= 32'd16) begin
              phase = PH_FMT;
              hsh = '0;
              crem = {32'd0, len} + len[0];
            end else if (id == TagData) begin
              if (fmt_tag != FmtPcm || (bits != 16'd8 && bits != 16'd16)) begin
                phase = PH_DONE;
              end else begin
                scaled = 1;
                crem = {32'd0, len};
                if (len == 0) begin
                  phase = PH_DONE;
                end else begin
                  phase = (bits == 16'd8) ? PH_DATA8 : PH_DATA16;
                end
              end
            end else begin
              phase = PH_SKIP;
              crem = {32'd0, len} + len[0];
              if (crem == 0) begin
                enter_hdr(body);
              end
            end
          end
        end
        PH_SKIP: begin
          r[0] = b;
          n = 1;
          crem--;
          if (crem == 0) begin
            enter_hdr({40'd0, pos} + 64'd1);
          end
        end
        PH_FMT: begin
          r[0] = b;
          n = 1;
          case (hsh)
            64'd0: fmt_tag[7:0] = b;
            64'd1: fmt_tag[15:8] = b;
            64'd14: bits[7:0] = b;
            64'd15: bits[15:8] = b;
            default: ;
          endcase
          hsh++;
          crem--;
          if (crem == 0) begin
            enter_hdr({40'd0, pos} + 64'd1);
          end
        end
        PH_DATA8: begin
          s = int'(b) - 128;
          v = 128 + (s * int'(vol)) / 1000;
          if (v < 0) v = 0;
          if (v > 255) v = 255;
          r[0] = v[7:0];
          n = 1;
          crem--;
          if (crem == 0) begin
            phase = PH_DONE;
          end
        end
        PH_DATA16: begin
          if (pending) begin
            w = {b, held};
            s = w;
            v = (s * int'(vol)) / 1000;
            if (v < -32768) v = -32768;
            if (v > 32767) v = 32767;
            r[0] = v[7:0];
            r[1] = v[15:8];
            n = 2;
            pending = 0;
            held = '0;
          end else if (crem == 64'd1 || last) begin
            r[0] = b;
            n = 1;
          end else begin
            held = b;
            pending = 1;
          end
          crem--;
          if (crem == 0) begin
            phase = PH_DONE;
          end
        end
        default: begin
          r[0] = b;
          n = 1;
        end
      endcase
      pos = pos + 24'd1;
      for (int k = 0; k < n; k++) begin
        item.value = r[k];
        item.run_last = (k == n - 1);
        item.file_end = (k == n - 1) && last;
        item.was_scaled = (k == n - 1) && last && scaled;
        due_q.push_back(item);
      end
      if (last) begin
        clear_parse();
      end
    endfunction

    function void check_out_byte(input out_byte_t got);
      out_byte_t want;
      if (due_q.size() == 0) begin
        flag($sformatf("Unexpected item: byte %02h run_last %b file_end %b was_scaled %b",
                       got.value, got.run_last, got.file_end, got.was_scaled));
        return;
      end
      want = due_q.pop_front();
      if (got.value !== want.value || got.run_last !== want.run_last ||
          got.file_end !== want.file_end || got.was_scaled !== want.was_scaled) begin
        flag($sformatf({"Mismatch: expected byte %02h run_last %b file_end %b was_scaled %b,",
                        " got byte %02h run_last %b file_end %b was_scaled %b"},
                       want.value, want.run_last, want.file_end, want.was_scaled,
                       got.value, got.run_last, got.file_end, got.was_scaled));
      end
    endfunction

    function void check_drained();
      if (due_q.size() != 0) begin
        flag($sformatf("%0d expected items never arrived", due_q.size()));
      end
    endfunction
  endclass

  logic        clk_i = 1'b0;
  logic        rst_ni;
  logic        in_valid_i;
  logic        in_stall_o;
  logic [7:0]  in_byte_i;
  logic        out_valid_o;
  logic        out_stall_i;
  logic [7:0]  out_byte_o;
  logic        run_last_o;
  logic        file_end_o;
  logic        was_scaled_o;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [2:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;

  wav_stream_checker tracker = new();
  logic [7:0]        file_q[$];
  bit                tx_calm;
  bit                tx_more;
  int unsigned       sent_cnt;

  wav_pcm_volume_scaler_unit DUT (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .in_byte_i    (in_byte_i),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .out_byte_o   (out_byte_o),
    .run_last_o   (run_last_o),
    .file_end_o   (file_end_o),
    .was_scaled_o (was_scaled_o),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .prdata       (prdata),
    .pready       (pready)
  );

  always #6 clk_i = ~clk_i;

  function automatic int unsigned draw_gap(input bit calm);
    int unsigned r;
    if (calm) return 0;
    r = $urandom_range(0, 99);
    if (r < 65) return 0;
    if (r < 90) return $urandom_range(1, 3);
    if (r < 98) return $urandom_range(4, 12);
    return $urandom_range(20, 40);
  endfunction

  function automatic void put_tag(input logic [31:0] t);
    for (int i = 3; i >= 0; i--) file_q.push_back(t[8*i +: 8]);
  endfunction

  function automatic void put_le32(input logic [31:0] v);
    for (int i = 0; i < 4; i++) file_q.push_back(v[8*i +: 8]);
  endfunction

  function automatic void flip_bit(input int unsigned lo_idx, input int unsigned hi_idx);
    int unsigned idx;
    idx = $urandom_range(lo_idx, hi_idx);
    file_q[idx] = file_q[idx] ^ (8'd1 << $urandom_range(0, 7));
  endfunction

  function automatic void build_file(input flaw_e flaw, output logic [31:0] total);
    int unsigned bits;
    int unsigned fmt_len;
    int unsigned data_len;
    int unsigned jl;
    int unsigned i;
    logic [15:0] fmt_tag;
    logic [15:0] smp;
    logic [31:0] len_field;
    logic [7:0]  bv;
    file_q.delete();
    bits = $urandom_range(0, 1) ? 16 : 8;
    if (flaw == F_BITS) bits = $urandom_range(0, 1) ? 24 : $urandom_range(0, 65535);
    fmt_tag = FmtPcm;
    if (flaw == F_FORMAT) fmt_tag = $urandom_range(0, 1) ? 16'd3 : 16'($urandom);
    fmt_len = (flaw == F_SHORTFMT) ? $urandom_range(0, 15) : $urandom_range(16, 19);
    data_len = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 3) : $urandom_range(4, 60);
    put_tag(TagRiff);
    put_le32($urandom);
    put_tag(TagWave);
    if (flaw == F_RIFF) flip_bit(0, 3);
    if (flaw == F_WAVE) flip_bit(8, 11);
    repeat ($urandom_range(0, 2)) begin
      jl = $urandom_range(0, 7);
      put_le32($urandom);
      put_le32(jl);
      repeat (jl + jl % 2) file_q.push_back(8'($urandom));
    end
    for (int part = 0; part < 2; part++) begin
      if ((part == 0) == (flaw != F_ORDER)) begin
        put_tag(TagFmt);
        put_le32(fmt_len);
        for (i = 0; i < fmt_len + fmt_len % 2; i++) begin
          case (i)
            0: bv = fmt_tag[7:0];
            1: bv = fmt_tag[15:8];
            14: bv = bits[7:0];
            15: bv = bits[15:8];
            default: bv = 8'($urandom);
          endcase
          file_q.push_back(bv);
        end
      end else begin
        put_tag(TagData);
        len_field = data_len;
        if (flaw == F_LONG) begin
          len_field = $urandom_range(0, 3) == 0 ? 32'hFFFF_FFFF : data_len + $urandom_range(1, 900);
        end
        put_le32(len_field);
        i = 0;
        while (i < data_len) begin
          if (bits == 16 && i + 1 < data_len) begin
            smp = 16'($urandom);
            if ($urandom_range(0, 5) == 0) begin
              case ($urandom_range(0, 3))
                0: smp = 16'h8000;
                1: smp = 16'h7FFF;
                2: smp = 16'hFFFF;
                default: smp = 16'h0001;
              endcase
            end
            file_q.push_back(smp[7:0]);
            file_q.push_back(smp[15:8]);
            i += 2;
          end else begin
            bv = 8'($urandom);
            if ($urandom_range(0, 5) == 0) bv = $urandom_range(0, 1) ? 8'hFF : 8'h00;
            file_q.push_back(bv);
            i++;
          end
        end
      end
    end
    if ($urandom_range(0, 3) != 0) begin
      repeat ($urandom_range(1, 12)) file_q.push_back(8'($urandom));
    end
    total = file_q.size();
    if (flaw == F_TRUNC) begin
      total = $urandom_range(0, 1) ? $urandom_range(1, 43) : $urandom_range(1, file_q.size() - 1);
      while (file_q.size() > total) void'(file_q.pop_back());
    end
    if (flaw == F_HUGE) total = $urandom_range(MaxFileBytesDef + 1, 24'hFF_FFFF);
  endfunction

  task automatic reg_write(input logic idx, input logic [31:0] data);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= data;
    @(posedge clk_i);
    penable <= 1'b1;
    @(negedge clk_i);
    while (!pready) @(negedge clk_i);
    @(posedge clk_i);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    tracker.set_reg(idx, data);
  endtask

  task automatic wait_idle();
    int unsigned guard;
    guard = 0;
    in_valid_i <= 1'b0;
    while (tracker.due_q.size() != 0 && guard < 200000) begin
      @(posedge clk_i);
      guard++;
    end
    repeat (8) @(posedge clk_i);
  endtask

  task automatic send_byte(input logic [7:0] b);
    int unsigned gap;
    gap = draw_gap(tx_calm);
    if (gap != 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_byte_i <= b;
    @(negedge clk_i);
    while (in_stall_o) @(negedge clk_i);
    @(posedge clk_i);
    tracker.note_byte(b);
    sent_cnt++;
  endtask

  task automatic play_file(input logic [31:0] vol, input logic [31:0] total, input bit oversize);
    wait_idle();
    reg_write(RegVolume, vol);
    reg_write(RegTotal, total);
    tx_calm = ($urandom_range(0, 3) == 0);
    if (oversize) begin
      // The size check fails at the WAVE tag; a length of one then ends the file.
      for (int i = 0; i < 14; i++) send_byte(file_q[i]);
      wait_idle();
      reg_write(RegTotal, 32'd1);
      send_byte(file_q[14]);
    end else begin
      foreach (file_q[i]) begin
        tx_more = (file_q.size() - i > 32);
        send_byte(file_q[i]);
      end
      tx_more = 0;
    end
  endtask

  initial begin
    #20_000_000;
    $display("RESULT: ERROR");
    $finish;
  end

  initial begin : drain
    int unsigned hold;
    int unsigned seen;
    int unsigned cyc;
    bit          calm;
    bit          long_done;
    out_byte_t   got;
    hold = 0;
    seen = 0;
    cyc = 0;
    calm = 0;
    long_done = 0;
    out_stall_i <= 1'b0;
    forever begin
      @(negedge clk_i);
      if (rst_ni && out_valid_o && !out_stall_i) begin
        got.value = out_byte_o;
        got.run_last = run_last_o;
        got.file_end = file_end_o;
        got.was_scaled = was_scaled_o;
        tracker.check_out_byte(got);
        seen++;
      end
      @(posedge clk_i);
      cyc++;
      if (cyc % 300 == 0) calm = ($urandom_range(0, 2) == 0);
      // One long hold-off lets the queue fill while items keep coming.
      if (!long_done && seen >= 400 && tx_more) begin
        long_done = 1;
        hold = 150;
      end else if (hold == 0) begin
        hold = draw_gap(calm);
      end
      out_stall_i <= (hold != 0);
      if (hold != 0) hold--;
    end
  end

  initial begin : stimulus
    logic [31:0] tot;
    logic [31:0] vol;
    flaw_e       flaw;
    rst_ni <= 1'b0;
    in_valid_i <= 1'b0;
    in_byte_i <= 8'h00;
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    paddr <= '0;
    pwdata <= '0;
    sent_cnt = 0;
    tx_calm = 0;
    tx_more = 0;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // A zero length makes every byte the last of its own file.
    file_q.delete();
    file_q.push_back(8'h00);
    file_q.push_back(8'hFF);
    file_q.push_back(8'h5A);
    play_file(32'd1023, 32'd0, 1'b0);
    file_q.delete();
    put_tag(32'h52494658);
    put_le32($urandom);
    play_file(32'd0, 32'd8, 1'b0);
    file_q.delete();
    put_tag(TagRiff);
    put_le32(32'd36);
    put_tag(TagWave);
    put_le32($urandom);
    play_file(32'd1000, 32'd16, 1'b0);
    build_file(F_NONE, tot);
    play_file(32'd500, 32'h00FF_FFFF, 1'b1);

    while (sent_cnt < 1550) begin
      flaw = ($urandom_range(0, 9) < 7) ? F_NONE : flaw_e'($urandom_range(1, 9));
      build_file(flaw, tot);
      case ($urandom_range(0, 7))
        0: vol = 32'd0;
        1: vol = 32'd1000;
        2: vol = 32'd1023;
        3: vol = 32'd1001;
        4: vol = 32'd1;
        default: vol = $urandom_range(0, 1023);
      endcase
      play_file(vol, tot, flaw == F_HUGE);
    end

    wait_idle();
    repeat (16) @(posedge clk_i);
    tracker.check_drained();
    if (tracker.errs == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

// ===== files.f =====
rtl/core/wpvs_pkg.sv
rtl/core/wpvs_front.sv
rtl/core/wpvs_queue.sv
rtl/core/wpvs_back.sv
rtl/core/wav_pcm_volume_scaler_unit.sv
tb/tb_wav_pcm_volume_scaler_unit.sv
